// ===== rtl/core/slm_pkg.sv =====
// Shared constants for the sorted list merge block.
// Store depth, derived index and count widths, and item mode codes.
// No dependencies.
package slm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

endpackage

// ===== rtl/core/slm_if.sv =====
// Valid/ready channels of the sorted list merge block: load/merge beats in,
// merged value beats out. Depends on slm_pkg.
interface slm_in_if;
  logic                                valid;
  logic                                ready;
  logic [slm_pkg::MODE_W-1:0]          mode;
  logic signed [slm_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [slm_pkg::DATA_W-1:0]   merged_value;
  logic                                last;

  modport source (output valid, output merged_value, output last, input ready);
  modport sink   (input valid, input merged_value, input last, output ready);
endinterface

// ===== rtl/core/slm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sorted_list_merge.sv =====
// Sorted list merge: two list stores in slm_ram, a merge walker and an
// output register. Depends on slm_pkg, slm_in_if, slm_out_if and slm_ram.
//
// A load beat (mode 0 or 1) appends its value to the first or second
// store; a value for a full store is dropped. A merge beat (mode 2)
// emits every stored value in ascending signed order, the first list
// winning ties, with last set on the final beat, then clears both
// counts. The merge gives one result per cycle while the sink is ready
// and holds off the input until the final beat; the one read port per
// store sets that pace.
// A merge of two empty lists and mode 3 emit nothing.
module sorted_list_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  slm_in_if.sink           in_i,
  slm_out_if.source        out_o
);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e                          state_q, state_d;
  logic [slm_pkg::CNT_W-1:0]       cnt_a_q, cnt_a_d;
  logic [slm_pkg::CNT_W-1:0]       cnt_b_q, cnt_b_d;
  logic [slm_pkg::CNT_W-1:0]       idx_a_q, idx_a_d;
  logic [slm_pkg::CNT_W-1:0]       idx_b_q, idx_b_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_last_q, out_last_d;
  logic [slm_pkg::DATA_W-1:0]      out_data_q, out_data_d;

  logic                            in_fire;
  logic                            we_a, we_b;
  logic [slm_pkg::DATA_W-1:0]      rdata_a, rdata_b;
  logic                            have_a, have_b, take_a, pick_fire, pick_last;
  logic [slm_pkg::CNT_W-1:0]       idx_a_nx, idx_b_nx;
  logic [slm_pkg::DATA_W-1:0]      pick_data;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign we_a = in_fire && (in_i.mode == slm_pkg::MODE_FIRST) &&
                (cnt_a_q < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));
  assign we_b = in_fire && (in_i.mode == slm_pkg::MODE_SECOND) &&
                (cnt_b_q < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH));

  // Read at the next index so the data matches the held index in the cycle after.
  // Loads and merge reads never share a cycle, so no forwarding is needed.
  slm_ram #(
    .WIDTH (slm_pkg::DATA_W),
    .DEPTH (slm_pkg::LIST_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[slm_pkg::ADDR_W-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (idx_a_d[slm_pkg::ADDR_W-1:0]),
    .rdata_o (rdata_a)
  );

  slm_ram #(
    .WIDTH (slm_pkg::DATA_W),
    .DEPTH (slm_pkg::LIST_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[slm_pkg::ADDR_W-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (idx_b_d[slm_pkg::ADDR_W-1:0]),
    .rdata_o (rdata_b)
  );

  assign have_a    = (idx_a_q < cnt_a_q);
  assign have_b    = (idx_b_q < cnt_b_q);
  assign take_a    = have_a && (!have_b || ($signed(rdata_a) <= $signed(rdata_b)));
  assign pick_data = take_a ? rdata_a : rdata_b;
  assign pick_fire = (state_q == ST_MERGE) && (!out_valid_q || out_o.ready);
  assign idx_a_nx  = take_a ? idx_a_q + slm_pkg::CNT_W'(1) : idx_a_q;
  assign idx_b_nx  = take_a ? idx_b_q : idx_b_q + slm_pkg::CNT_W'(1);
  assign pick_last = (idx_a_nx == cnt_a_q) && (idx_b_nx == cnt_b_q);

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (we_a) begin
          cnt_a_d = cnt_a_q + slm_pkg::CNT_W'(1);
        end
        if (we_b) begin
          cnt_b_d = cnt_b_q + slm_pkg::CNT_W'(1);
        end
        if (in_fire && (in_i.mode == slm_pkg::MODE_MERGE) &&
            ((cnt_a_q != '0) || (cnt_b_q != '0))) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (pick_fire) begin
          out_valid_d = 1'b1;
          out_data_d  = pick_data;
          out_last_d  = pick_last;
          idx_a_d     = idx_a_nx;
          idx_b_d     = idx_b_nx;
          if (pick_last) begin
            state_d = ST_IDLE;
            cnt_a_d = '0;
            cnt_b_d = '0;
            idx_a_d = '0;
            idx_b_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      idx_a_q     <= '0;
      idx_b_q     <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      idx_a_q     <= idx_a_d;
      idx_b_q     <= idx_b_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = out_data_q;
  assign out_o.last         = out_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH)) &&
    (cnt_b_q <= slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH)))
    else $error("list count beyond store depth");

  a_merge_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (have_a || have_b))
    else $error("merge walker running with both lists exhausted");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pick_fire && pick_last) |=>
      (state_q == ST_IDLE) && (cnt_a_q == '0) && (cnt_b_q == '0) && out_last_q)
    else $error("final beat did not return to idle with cleared counts");

  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (idx_a_q == '0) && (idx_b_q == '0))
    else $error("walk indices not cleared while idle");
`endif

endmodule
